// ----- hw/rtl/ppa_pkg.sv -----
package ppa_pkg;

    // converter resolution
    localparam int ADC_BITS = 12;

    // input function codes
    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_CLOSE  = 2'd1;
    localparam logic [1:0] FUNC_REPORT = 2'd2;

    // result kinds
    localparam logic KIND_READING = 1'b0;
    localparam logic KIND_POWER   = 1'b1;

    // field widths
    localparam int MA_W  = 13;
    localparam int W_W   = 11;
    localparam int V_W   = 8;
    localparam int TOT_W = 32;
    localparam int CNT_W = 16;

    localparam logic [V_W-1:0]  VOLT_RESET = 8'd120;
    localparam logic [MA_W-1:0] MA_MAX     = '1;
    localparam logic [W_W-1:0]  W_MAX      = '1;

    // milliamp scaling: ma = floor(span * MA_NUMER / MA_DENOM)
    localparam longint unsigned MA_NUMER = 64'd3300000;
    localparam longint unsigned MA_DENOM =
        ((64'd1 << ADC_BITS) * 64'd2 * 64'd1414 * 64'd185) / 64'd1000;
    // reciprocal estimate, at most one low
    localparam int              MA_SH = 24;
    localparam longint unsigned MA_K  = (MA_NUMER << MA_SH) / MA_DENOM;

    localparam int K_W   = $clog2(MA_K + 1);
    localparam int PK_W  = ADC_BITS + K_W;
    localparam int Q_W   = MA_W + 1;
    localparam int D_W   = $clog2(MA_DENOM + 1);
    localparam int QD_W  = Q_W + D_W;
    localparam int N_W   = $clog2(MA_NUMER + 1);
    localparam int PN_W  = ADC_BITS + N_W;

    // power scaling
    localparam int W_SCALE = 1000;
    localparam int NUM_W   = TOT_W + V_W;
    localparam int DEN_W   = CNT_W + 10;
    localparam int DCNT_W  = $clog2(W_W);

    // controller to datapath commands
    typedef struct packed {
        logic sample_upd;
        logic close_latch;
        logic ma_k;
        logic ma_qd;
        logic ma_pn;
        logic ma_fin;
        logic pw_mul;
        logic pw_sat;
        logic pw_div;
        logic pw_fin;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic count_zero;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

// ----- hw/rtl/current_peak_to_peak_power_averager.sv -----
// sample transfers: back to back, one per cycle
// window close: states MA_K, MA_QD, MA_PN, MA_FIN (reciprocal multiply chain), then the result; next transfer in idle
// power report: states PW_MUL, PW_SAT, PW_DIV (restoring divider, saturated or not), PW_FIN, then the result;
// next transfer in idle; a result still waiting at the output holds MA_FIN or PW_FIN until it is taken
// report with no readings and unused function codes: stays idle, no result
// reset (synchronous, active low): window empty, total and count zero, line voltage 120
module current_peak_to_peak_power_averager (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // item input
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_func,
    input  logic [11:0]                 i_sample,
    // line voltage register
    input  logic                        i_cfg_we,
    input  logic [ppa_pkg::V_W-1:0]     i_cfg_wdata,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_kind,
    output logic [ppa_pkg::MA_W-1:0]    o_milliamps,
    output logic                        o_range_error,
    output logic [ppa_pkg::W_W-1:0]     o_watts
);

    // controller sequences the multiply steps of a close and the
    // divider steps of a report; the datapath holds all arithmetic state
    ppa_pkg::t_cmd    cmd;
    ppa_pkg::t_status status;

    // accepts a transfer only in idle; samples return to idle at once
    ppa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // min/max window, milliamp scaling, running total and the power divider;
    // the result register lets the next item in while a result waits
    ppa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_sample      (i_sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_milliamps   (o_milliamps),
        .o_range_error (o_range_error),
        .o_watts       (o_watts)
    );

endmodule

// ----- hw/rtl/ppa_ctrl.sv -----
module ppa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_func,
    input  ppa_pkg::t_status  i_status,
    output logic              o_in_ready,
    output ppa_pkg::t_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MA_K,
        S_MA_QD,
        S_MA_PN,
        S_MA_FIN,
        S_PW_MUL,
        S_PW_SAT,
        S_PW_DIV,
        S_PW_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_func)
                        ppa_pkg::FUNC_SAMPLE: begin
                            o_cmd.sample_upd = 1'b1;
                        end
                        ppa_pkg::FUNC_CLOSE: begin
                            o_cmd.close_latch = 1'b1;
                            n_state           = S_MA_K;
                        end
                        ppa_pkg::FUNC_REPORT: begin
                            if (!i_status.count_zero) n_state = S_PW_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            S_MA_K: begin
                o_cmd.ma_k = 1'b1;
                n_state    = S_MA_QD;
            end
            S_MA_QD: begin
                o_cmd.ma_qd = 1'b1;
                n_state     = S_MA_PN;
            end
            S_MA_PN: begin
                o_cmd.ma_pn = 1'b1;
                n_state     = S_MA_FIN;
            end
            S_MA_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.ma_fin = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_PW_MUL: begin
                o_cmd.pw_mul = 1'b1;
                n_state      = S_PW_SAT;
            end
            S_PW_SAT: begin
                o_cmd.pw_sat = 1'b1;
                n_state      = S_PW_DIV;
            end
            S_PW_DIV: begin
                o_cmd.pw_div = 1'b1;
                if (i_status.div_last) n_state = S_PW_FIN;
            end
            S_PW_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.pw_fin = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/ppa_dp.sv -----
module ppa_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ppa_pkg::t_cmd                   i_cmd,
    output ppa_pkg::t_status                o_status,
    input  logic [11:0]                     i_sample,
    input  logic                            i_cfg_we,
    input  logic [ppa_pkg::V_W-1:0]         i_cfg_wdata,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_kind,
    output logic [ppa_pkg::MA_W-1:0]        o_milliamps,
    output logic                            o_range_error,
    output logic [ppa_pkg::W_W-1:0]         o_watts
);

    localparam int AB = ppa_pkg::ADC_BITS;

    // window and accumulation state
    logic [AB:0]                    r_wmin;
    logic [AB-1:0]                  r_wmax;
    logic [ppa_pkg::TOT_W-1:0]      r_total;
    logic [ppa_pkg::CNT_W-1:0]      r_count;
    logic [ppa_pkg::V_W-1:0]        r_volt;

    // milliamp path
    logic [AB-1:0]                  r_span;
    logic                           r_empty;
    logic [ppa_pkg::PK_W-1:0]       r_pk;
    logic [ppa_pkg::Q_W-1:0]        r_q;
    logic [ppa_pkg::QD_W-1:0]       r_qd;
    logic [ppa_pkg::PN_W-1:0]       r_pn;

    // power path
    logic [ppa_pkg::NUM_W-1:0]      r_num;
    logic [ppa_pkg::DEN_W-1:0]      r_den;
    logic [ppa_pkg::NUM_W-1:0]      r_rem;
    logic [ppa_pkg::NUM_W-1:0]      r_dsh;
    logic [ppa_pkg::W_W-1:0]        r_quo;
    logic [ppa_pkg::DCNT_W-1:0]     r_dcnt;

    // output register
    logic                           r_out_valid;
    logic                           r_kind;
    logic [ppa_pkg::MA_W-1:0]       r_ma;
    logic                           r_err;
    logic [ppa_pkg::W_W-1:0]        r_watts;

    logic [AB-1:0]                  code;
    logic [ppa_pkg::Q_W-1:0]        q_est;
    logic [ppa_pkg::PN_W-1:0]       rem_ma;
    logic [ppa_pkg::Q_W-1:0]        q_fix;
    logic [ppa_pkg::MA_W-1:0]       ma_val;
    logic [ppa_pkg::TOT_W:0]        tot_sum;
    logic                           pw_over;
    logic                           rem_ge;
    logic                           out_load;

    assign code   = AB'(i_sample);
    assign q_est  = ppa_pkg::Q_W'(r_pk >> ppa_pkg::MA_SH);
    assign rem_ma = r_pn - ppa_pkg::PN_W'(r_qd);
    assign q_fix  = r_q + ppa_pkg::Q_W'(rem_ma >= ppa_pkg::PN_W'(ppa_pkg::MA_DENOM));

    always_comb begin
        if (r_empty) begin
            ma_val = '0;
        end else if (q_fix > ppa_pkg::Q_W'(ppa_pkg::MA_MAX)) begin
            ma_val = ppa_pkg::MA_MAX;
        end else begin
            ma_val = ppa_pkg::MA_W'(q_fix);
        end
    end

    assign tot_sum  = {1'b0, r_total} + (ppa_pkg::TOT_W + 1)'(ma_val);
    assign pw_over  = r_num >= (ppa_pkg::NUM_W'(r_den) << ppa_pkg::W_W);
    assign rem_ge   = r_rem >= r_dsh;
    assign out_load = i_cmd.ma_fin | i_cmd.pw_fin;

    assign o_status.count_zero = (r_count == '0);
    assign o_status.div_last   = (r_dcnt == '0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wmin      <= (AB + 1)'(1) << AB;
            r_wmax      <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_volt      <= ppa_pkg::VOLT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_volt <= i_cfg_wdata;
            if (i_cmd.sample_upd) begin
                if (code > r_wmax) r_wmax <= code;
                if ({1'b0, code} < r_wmin) r_wmin <= {1'b0, code};
            end
            if (i_cmd.close_latch) begin
                r_wmin <= (AB + 1)'(1) << AB;
                r_wmax <= '0;
            end
            if (i_cmd.ma_fin) begin
                r_total <= tot_sum[ppa_pkg::TOT_W] ? '1 : tot_sum[ppa_pkg::TOT_W-1:0];
                if (r_count != '1) r_count <= r_count + 1'b1;
            end
            if (i_cmd.pw_fin) begin
                r_total <= '0;
                r_count <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.close_latch) begin
            r_empty <= {1'b0, r_wmax} < r_wmin;
            r_span  <= r_wmax - r_wmin[AB-1:0];
        end
        if (i_cmd.ma_k) r_pk <= ppa_pkg::PK_W'(r_span) * ppa_pkg::PK_W'(ppa_pkg::MA_K);
        if (i_cmd.ma_qd) begin
            r_q  <= q_est;
            r_qd <= ppa_pkg::QD_W'(q_est) * ppa_pkg::QD_W'(ppa_pkg::MA_DENOM);
        end
        if (i_cmd.ma_pn) begin
            r_pn <= ppa_pkg::PN_W'(r_span) * ppa_pkg::PN_W'(ppa_pkg::MA_NUMER);
        end
        if (i_cmd.pw_mul) begin
            r_num <= ppa_pkg::NUM_W'(r_total) * ppa_pkg::NUM_W'(r_volt);
            r_den <= ppa_pkg::DEN_W'(r_count) * ppa_pkg::DEN_W'(ppa_pkg::W_SCALE);
        end
        if (i_cmd.pw_sat) begin
            r_quo  <= pw_over ? ppa_pkg::W_MAX : '0;
            r_rem  <= pw_over ? '0 : r_num;
            r_dsh  <= ppa_pkg::NUM_W'(r_den) << (ppa_pkg::W_W - 1);
            r_dcnt <= ppa_pkg::DCNT_W'(ppa_pkg::W_W - 1);
        end
        // restoring division, one quotient bit per cycle
        if (i_cmd.pw_div) begin
            if (rem_ge) r_rem <= r_rem - r_dsh;
            r_quo  <= pw_over ? r_quo : {r_quo[ppa_pkg::W_W-2:0], rem_ge};
            r_dsh  <= r_dsh >> 1;
            r_dcnt <= r_dcnt - 1'b1;
        end
        if (i_cmd.ma_fin) begin
            r_kind  <= ppa_pkg::KIND_READING;
            r_ma    <= ma_val;
            r_err   <= r_empty;
            r_watts <= '0;
        end
        if (i_cmd.pw_fin) begin
            r_kind  <= ppa_pkg::KIND_POWER;
            r_ma    <= '0;
            r_err   <= 1'b0;
            r_watts <= r_quo;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_milliamps   = r_ma;
    assign o_range_error = r_err;
    assign o_watts       = r_watts;

endmodule

// ----- hw/rtl/ppa_checker.sv -----
module ppa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [1:0]                  i_func,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_kind,
    input logic [ppa_pkg::MA_W-1:0]    o_milliamps,
    input logic                        o_range_error,
    input logic [ppa_pkg::W_W-1:0]     o_watts
);

    // a sample transfer never stalls the next item
    a_sample_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_func == ppa_pkg::FUNC_SAMPLE |=> o_in_ready)
        else $error("input not ready after sample transfer");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
        && $stable(o_milliamps) && $stable(o_range_error) && $stable(o_watts))
        else $error("stalled result changed");

    a_reading_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == ppa_pkg::KIND_READING |-> o_watts == '0)
        else $error("window reading carries watts");

    a_report_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == ppa_pkg::KIND_POWER |-> o_milliamps == '0 && !o_range_error)
        else $error("power report carries current fields");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> o_milliamps == '0)
        else $error("empty window with nonzero current");

endmodule

bind current_peak_to_peak_power_averager ppa_checker u_ppa_checker (.*);

// ----- test/testbench.sv -----
module testbench;

    // function code the block leaves alone
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // peak-to-peak span to milliamps: span * 3300000 / (4096 * 2 * 1414 * 185 / 1000)
    localparam longint unsigned SPAN_MA_NUM = 64'd3300000;
    localparam longint unsigned SPAN_MA_DEN = 64'd2142945;
    localparam longint unsigned READING_CAP = 64'd8191;
    localparam longint unsigned POWER_CAP   = 64'd2047;
    localparam longint unsigned TOTAL_CAP   = 64'hFFFF_FFFF;

    // cycles to let pass once idle, enough for the slowest report
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [1:0]  func;
        logic [11:0] sample;
        bit          hold;      // wait for every owed result before this transfer
    } t_meter_item;

    typedef struct {
        logic                     kind;
        logic [ppa_pkg::MA_W-1:0] milliamps;
        logic                     range_error;
        logic [ppa_pkg::W_W-1:0]  watts;
    } t_meter_result;

    // stimulus side, all known from time zero
    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic [1:0]              func        = ppa_pkg::FUNC_SAMPLE;
    logic [11:0]             sample      = '0;
    logic                    cfg_we      = 1'b0;
    logic [ppa_pkg::V_W-1:0] cfg_wdata   = '0;
    logic                    out_ready   = 1'b1;

    // block outputs
    logic                     in_ready;
    logic                     out_valid;
    logic                     kind;
    logic [ppa_pkg::MA_W-1:0] milliamps;
    logic                     range_error;
    logic [ppa_pkg::W_W-1:0]  watts;

    // predicted meter state
    logic [12:0]             win_lo;
    logic [11:0]             win_hi;
    logic [31:0]             amp_total;
    logic [15:0]             amp_count;
    logic [ppa_pkg::V_W-1:0] volts;

    t_meter_item     meter_items[$];      // items waiting for the driver
    t_meter_result   owed_results[$];     // readings and reports still to come
    t_meter_item     next_item;

    int  items_pushed  = 0;
    int  items_taken   = 0;     // transfers in, updated at the clock edge
    int  results_owed  = 0;     // mirror of owed_results size, updated at the clock edge
    int  mismatches    = 0;
    int  readings_n    = 0;
    int  reports_n     = 0;
    int  gap_left      = 0;
    int  stall_left    = 0;
    bit  gaps_on       = 1'b1;
    bit  stalls_on     = 1'b1;
    bit  quiet         = 1'b0;  // no idling on either side
    int  mixed_volts;

    current_peak_to_peak_power_averager i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_func        (func),
        .i_sample      (sample),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_kind        (kind),
        .o_milliamps   (milliamps),
        .o_range_error (range_error),
        .o_watts       (watts)
    );

    always #10 clk = ~clk;

    // one line per mismatch, capped so a broken block cannot flood the log
    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("testbench: mismatch in %s at %0t: got %0d, want %0d",
                     what, $time, got, want);
    endtask

    // advance the meter by one accepted item and queue what it owes
    task automatic meter_predict(input logic [1:0] f, input logic [11:0] s);
        t_meter_result   r;
        longint unsigned ma;
        longint unsigned total_next;
        longint unsigned w;
        r = '{kind: ppa_pkg::KIND_READING, milliamps: '0, range_error: 1'b0, watts: '0};
        case (f)
            ppa_pkg::FUNC_SAMPLE: begin
                if (s > win_hi)
                    win_hi = s;
                if ({1'b0, s} < win_lo)
                    win_lo = {1'b0, s};
            end
            ppa_pkg::FUNC_CLOSE: begin
                // an empty window still counts as a zero reading
                ma = 0;
                r.range_error = ({1'b0, win_hi} < win_lo);
                if (!r.range_error) begin
                    ma = 64'(win_hi - win_lo[11:0]) * SPAN_MA_NUM / SPAN_MA_DEN;
                    if (ma > READING_CAP)
                        ma = READING_CAP;
                end
                total_next = 64'(amp_total) + ma;
                amp_total  = (total_next > TOTAL_CAP) ? '1 : total_next[31:0];
                if (amp_count != '1)
                    amp_count++;
                win_lo = 13'd4096;
                win_hi = '0;
                r.milliamps = ma[ppa_pkg::MA_W-1:0];
                owed_results.push_back(r);
            end
            ppa_pkg::FUNC_REPORT: begin
                // no readings: nothing comes back and nothing changes
                if (amp_count != 0) begin
                    w = 64'(amp_total) * 64'(volts) / (64'(amp_count) * 64'd1000);
                    if (w > POWER_CAP)
                        w = POWER_CAP;
                    amp_total = '0;
                    amp_count = '0;
                    r.kind  = ppa_pkg::KIND_POWER;
                    r.watts = w[ppa_pkg::W_W-1:0];
                    owed_results.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    // compare one delivered result with the oldest one owed
    task automatic check_result();
        t_meter_result want;
        if (owed_results.size() == 0) begin
            report_mismatch("result with nothing owed", kind, -1);
            return;
        end
        want = owed_results.pop_front();
        if (kind !== want.kind)
            report_mismatch("kind", kind, want.kind);
        if (milliamps !== want.milliamps)
            report_mismatch("milliamps", milliamps, want.milliamps);
        if (range_error !== want.range_error)
            report_mismatch("range_error", range_error, want.range_error);
        if (watts !== want.watts)
            report_mismatch("watts", watts, want.watts);
        if (want.kind == ppa_pkg::KIND_POWER)
            reports_n++;
        else
            readings_n++;
    endtask

    // monitor: results are checked before the same edge's input is predicted,
    // so a result can never be matched against an item taken at that edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready) begin
                meter_predict(func, sample);
                items_taken <= items_taken + 1;
            end
            results_owed <= owed_results.size();
        end
    end

    // driver: moves items from the queue onto the input channel
    always @(posedge clk) begin
        if (rst_n && (!in_valid || in_ready)) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end else if (meter_items.size() != 0 &&
                         !(meter_items[0].hold && (in_valid || results_owed != 0))) begin
                next_item = meter_items.pop_front();
                in_valid <= 1'b1;
                func     <= next_item.func;
                sample   <= next_item.sample;
                // idle burst after this transfer, in some stretches only
                if (!quiet && gaps_on && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 14);
                if ($urandom_range(0, 39) == 0)
                    gaps_on = !gaps_on;
            end else begin
                // queue empty, or a held item waits until its elder results are all back
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall bursts on the result channel
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_ready <= (stall_left == 0);
        end else if (!quiet && stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
        if ($urandom_range(0, 49) == 0)
            stalls_on = !stalls_on;
    end

    task automatic push_item(input logic [1:0] f, input logic [11:0] s, input bit hold);
        meter_items.push_back('{func: f, sample: s, hold: hold});
        items_pushed++;
    endtask

    // extremes often, anything else otherwise
    function automatic logic [11:0] pick_code();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return 12'd4095;
            default: return 12'($urandom);
        endcase
    endfunction

    // mostly well-formed windows, some noise and stray reports
    task automatic push_random_window();
        int pick;
        int n;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            push_item(FUNC_UNUSED, 12'($urandom), 1'b0);
        end else if (pick == 1) begin
            push_item(ppa_pkg::FUNC_REPORT, 12'($urandom), 1'b0);
        end else if (pick == 2) begin
            push_item(ppa_pkg::FUNC_CLOSE, 12'($urandom), 1'b0);
        end else begin
            n = $urandom_range(1, 6);
            repeat (n)
                push_item(ppa_pkg::FUNC_SAMPLE, pick_code(), 1'b0);
            push_item(ppa_pkg::FUNC_CLOSE, 12'($urandom), 1'b0);
            if ($urandom_range(0, 3) == 0)
                push_item(ppa_pkg::FUNC_REPORT, 12'($urandom), $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic random_phase(input int n);
        int start;
        @(negedge clk);
        start = items_pushed;
        while (items_pushed - start < n)
            push_random_window();
    endtask

    // wait until every item is in and every result is out, then let the block settle
    task automatic drain();
        do
            @(posedge clk);
        while (items_taken != items_pushed || results_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_volts(input logic [ppa_pkg::V_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        volts      = v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        win_lo    = 13'd4096;
        win_hi    = '0;
        amp_total = '0;
        amp_count = '0;
        volts     = ppa_pkg::VOLT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset voltage
        @(negedge clk);
        push_item(ppa_pkg::FUNC_REPORT, 12'd0, 1'b0);        // report before any reading
        push_item(FUNC_UNUSED, 12'hFFF, 1'b0);               // unused code
        push_item(ppa_pkg::FUNC_CLOSE, 12'd0, 1'b0);         // empty window
        push_item(ppa_pkg::FUNC_SAMPLE, 12'd0, 1'b0);        // full span
        push_item(ppa_pkg::FUNC_SAMPLE, 12'd4095, 1'b0);
        push_item(ppa_pkg::FUNC_CLOSE, 12'hFFF, 1'b0);
        push_item(ppa_pkg::FUNC_SAMPLE, 12'd2048, 1'b0);     // single sample, zero span
        push_item(ppa_pkg::FUNC_CLOSE, 12'd0, 1'b0);
        push_item(ppa_pkg::FUNC_SAMPLE, 12'hAAA, 1'b0);      // alternating bit patterns
        push_item(ppa_pkg::FUNC_SAMPLE, 12'h555, 1'b0);
        push_item(ppa_pkg::FUNC_SAMPLE, 12'h800, 1'b0);
        push_item(ppa_pkg::FUNC_CLOSE, 12'd0, 1'b0);
        push_item(ppa_pkg::FUNC_SAMPLE, 12'd100, 1'b0);      // report in the middle of a window
        push_item(ppa_pkg::FUNC_SAMPLE, 12'd300, 1'b0);
        push_item(ppa_pkg::FUNC_REPORT, 12'd0, 1'b1);
        push_item(ppa_pkg::FUNC_CLOSE, 12'd0, 1'b0);         // window survives the report
        push_item(ppa_pkg::FUNC_REPORT, 12'hFFF, 1'b1);
        push_item(ppa_pkg::FUNC_REPORT, 12'd0, 1'b0);        // nothing left to report
        push_item(FUNC_UNUSED, 12'd0, 1'b0);
        random_phase(80);
        drain();

        // random phases across the voltage range
        set_volts(8'd255);
        random_phase(80);
        drain();
        set_volts(8'd1);
        random_phase(80);
        drain();
        set_volts(8'd0);
        random_phase(80);
        drain();
        mixed_volts = $urandom_range(2, 254);
        set_volts(ppa_pkg::V_W'(mixed_volts));
        random_phase(80);
        drain();

        // last part, no idling on either side: windows back to back, then a report
        quiet = 1'b1;
        set_volts(8'd255);
        wait (stall_left == 0);
        @(negedge clk);
        repeat (10) begin
            push_item(ppa_pkg::FUNC_SAMPLE, pick_code(), 1'b0);
            push_item(ppa_pkg::FUNC_SAMPLE, pick_code(), 1'b0);
            push_item(ppa_pkg::FUNC_CLOSE, 12'd0, 1'b0);
        end
        push_item(ppa_pkg::FUNC_REPORT, 12'd0, 1'b0);
        drain();

        if (owed_results.size() != 0)
            report_mismatch("results never delivered", owed_results.size(), 0);
        $display("testbench: %0d transfers in, %0d window readings and %0d power reports checked",
                 items_taken, readings_n, reports_n);
        $display("testbench: line voltage 120, 255, 1, 0 and %0d, stalls, gaps and a quiet stretch",
                 mixed_volts);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // run limit, several times the slowest correct run
    initial begin
        #4_000_000;
        $display("testbench: timed out with %0d results owed", owed_results.size());
        $display("testbench: done, errors");
        $finish;
    end

endmodule
